/* design/bop_pkg.sv */
`default_nettype none
package bop_pkg;
	localparam int ADDR_BITS   = 48;
	localparam int RR_ENTRIES  = 256;
	localparam int RR_IDX_BITS = 8;
	localparam int NUM_OFFSETS = 52;
	localparam int PTR_BITS    = 6;
	localparam int BLOCK_SHIFT = 6;
	localparam int SCORE_BITS  = 6;
	localparam int OFF_BITS    = 9;

	localparam logic [1:0] CFG_SCORE_MAX = 2'd0;
	localparam logic [1:0] CFG_ROUND_MAX = 2'd1;
	localparam logic [1:0] CFG_BAD_SCORE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SEARCH, ST_UPDATE, ST_SCAN, ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic take;
		logic srch_start;
		logic srch_step;
		logic update;
		logic scan_start;
		logic scan_step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_fill;
		logic srch_last;
		logic end_phase;
		logic scan_last;
		logic out_busy;
	} sts_t;

	function automatic logic [OFF_BITS-1:0] cand_at(input logic [PTR_BITS-1:0] i);
		logic [OFF_BITS-1:0] r;
		case (i)
			6'd0: r = 9'd1;    6'd1: r = 9'd2;    6'd2: r = 9'd3;    6'd3: r = 9'd4;
			6'd4: r = 9'd5;    6'd5: r = 9'd6;    6'd6: r = 9'd8;    6'd7: r = 9'd9;
			6'd8: r = 9'd10;   6'd9: r = 9'd12;   6'd10: r = 9'd15;  6'd11: r = 9'd16;
			6'd12: r = 9'd18;  6'd13: r = 9'd20;  6'd14: r = 9'd24;  6'd15: r = 9'd25;
			6'd16: r = 9'd27;  6'd17: r = 9'd30;  6'd18: r = 9'd32;  6'd19: r = 9'd36;
			6'd20: r = 9'd40;  6'd21: r = 9'd45;  6'd22: r = 9'd48;  6'd23: r = 9'd50;
			6'd24: r = 9'd54;  6'd25: r = 9'd60;  6'd26: r = 9'd64;  6'd27: r = 9'd72;
			6'd28: r = 9'd75;  6'd29: r = 9'd80;  6'd30: r = 9'd81;  6'd31: r = 9'd90;
			6'd32: r = 9'd96;  6'd33: r = 9'd100; 6'd34: r = 9'd108; 6'd35: r = 9'd120;
			6'd36: r = 9'd125; 6'd37: r = 9'd128; 6'd38: r = 9'd135; 6'd39: r = 9'd144;
			6'd40: r = 9'd150; 6'd41: r = 9'd160; 6'd42: r = 9'd162; 6'd43: r = 9'd180;
			6'd44: r = 9'd192; 6'd45: r = 9'd200; 6'd46: r = 9'd216; 6'd47: r = 9'd225;
			6'd48: r = 9'd240; 6'd49: r = 9'd243; 6'd50: r = 9'd250;
			default: r = 9'd256;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* design/bop_ram.sv */
`default_nettype none
module bop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/bop_ctrl.sv */
`default_nettype none
module bop_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire bop_pkg::sts_t sts,
	output bop_pkg::cmd_t      cmd
);
	import bop_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_SEARCH;
			ST_SEARCH: if (sts.is_fill || sts.srch_last) state_d = ST_UPDATE;
			ST_UPDATE: state_d = (!sts.is_fill && sts.end_phase) ? ST_SCAN : ST_DONE;
			ST_SCAN:   if (sts.scan_last) state_d = ST_DONE;
			ST_DONE:   if (!sts.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				cmd.srch_start = in_valid;
			end
			ST_SEARCH: cmd.srch_step = 1'b1;
			ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.finish = sts.scan_last;
			end
			ST_DONE: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* design/bop_dp.sv */
`default_nettype none
module bop_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bop_pkg::cmd_t                 cmd,
	output bop_pkg::sts_t                      sts,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [5:0]                    cfg_data,
	input  wire logic                          op,
	input  wire logic [bop_pkg::ADDR_BITS-1:0] addr,
	input  wire logic                          miss,
	input  wire logic                          prefetched_hit,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               issue,
	output logic [bop_pkg::ADDR_BITS-1:0]      prefetch_addr,
	output logic                               mark_prefetched
);
	import bop_pkg::*;
	localparam int SCAN_LAST = NUM_OFFSETS - 1;

	logic [5:0] score_max_q, round_max_q;
	logic [4:0] bad_score_q;
	logic       op_q, iss_q;
	logic [ADDR_BITS-1:0] addr_q, target_q, paddr_q;
	logic [OFF_BITS-1:0]  active_q, best_off_q;
	logic [4:0] round_q;
	logic [PTR_BITS-1:0] ptr_q, scan_q, scan_s1;
	logic scan_vld_s1;
	logic [SCORE_BITS-1:0] best_sc_q;
	logic found_q;
	logic [RR_IDX_BITS:0] rcnt_q;
	logic [RR_IDX_BITS-1:0] raddr;
	logic rd_vld_q;
	logic [ADDR_BITS-1:0] rdata;
	logic [RR_IDX_BITS-1:0] clr_q;
	logic tab_we;
	logic [RR_IDX_BITS-1:0] tab_wa;
	logic [ADDR_BITS-1:0] tab_wd;
	logic sc_we;
	logic [PTR_BITS-1:0] sc_wa, sc_ra;
	logic [SCORE_BITS-1:0] sc_wd, sc_rdata;
	logic [SCORE_BITS-1:0] cur_sc, new_sc;
	logic [5:0] rmax;
	logic hit_any, score_end, round_end, scan_win;

	assign cur_sc = sc_rdata;
	assign new_sc = (hit_any && cur_sc != '1) ? cur_sc + 1'b1 : cur_sc;
	assign rmax = (round_max_q == 6'd0) ? 6'd1 : (round_max_q > 6'd32 ? 6'd32 : round_max_q);
	assign hit_any = found_q || (rd_vld_q && rdata == target_q);
	assign score_end = hit_any && new_sc >= score_max_q;
	assign round_end = (ptr_q == SCAN_LAST[PTR_BITS-1:0]) && ({1'b0, round_q} + 6'd1 >= rmax);
	assign scan_win = (sc_rdata >= best_sc_q) && (sc_rdata > {1'b0, bad_score_q});

	assign tab_we = cmd.clr_step || (cmd.update && op_q);
	assign tab_wa = cmd.clr_step ? clr_q : (addr_q[7:0] & addr_q[15:8]);
	assign tab_wd = cmd.clr_step ? '0
		: addr_q - ({{(ADDR_BITS-OFF_BITS){1'b0}}, active_q} << BLOCK_SHIFT);
	assign raddr = rcnt_q[RR_IDX_BITS-1:0];

	bop_ram #(.WIDTH(ADDR_BITS), .DEPTH(RR_ENTRIES)) u_rr (
		.clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd),
		.raddr(raddr), .rdata(rdata)
	);

	// score table: cleared by the reset pass, written on update, zeroed behind the scan
	assign sc_we = cmd.clr_step || (cmd.update && !op_q) || (cmd.scan_step && scan_vld_s1);
	assign sc_wa = cmd.clr_step ? clr_q[PTR_BITS-1:0] : (cmd.update ? ptr_q : scan_s1);
	assign sc_wd = cmd.update ? new_sc : '0;
	assign sc_ra = cmd.scan_step ? scan_q : ptr_q;

	bop_ram #(.WIDTH(SCORE_BITS), .DEPTH(1 << PTR_BITS)) u_sc (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd),
		.raddr(sc_ra), .rdata(sc_rdata)
	);

	assign sts.clr_last  = (clr_q == '1);
	assign sts.is_fill   = op_q;
	assign sts.srch_last = rd_vld_q && (rcnt_q == RR_ENTRIES[RR_IDX_BITS:0]);
	assign sts.end_phase = score_end || round_end;
	assign sts.scan_last = scan_vld_s1 && (scan_s1 == SCAN_LAST[PTR_BITS-1:0]);
	assign sts.out_busy  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_max_q <= 6'd31;
			round_max_q <= 6'd32;
			bad_score_q <= 5'd0;
			active_q <= '0;
			round_q <= '0;
			ptr_q <= '0;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCORE_MAX: score_max_q <= cfg_data;
					CFG_ROUND_MAX: round_max_q <= cfg_data;
					CFG_BAD_SCORE: bad_score_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.out_load) out_valid <= 1'b1;
			if (cmd.update && !op_q && !score_end) begin
				if (ptr_q == SCAN_LAST[PTR_BITS-1:0]) begin
					ptr_q <= '0;
					if ({1'b0, round_q} + 6'd1 < rmax) round_q <= round_q + 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			// phase end: adopt the best, clear counters
			if (cmd.finish) begin
				active_q <= scan_win ? cand_at(scan_s1) : best_off_q;
				round_q <= '0;
				ptr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= op; addr_q <= addr;
			iss_q <= !op && active_q != '0 && (miss || prefetched_hit);
			paddr_q <= addr + ({{(ADDR_BITS-OFF_BITS){1'b0}}, active_q} << BLOCK_SHIFT);
			target_q <= addr - ({{(ADDR_BITS-OFF_BITS){1'b0}}, cand_at(ptr_q)} << BLOCK_SHIFT);
		end
		if (cmd.srch_start) begin
			rcnt_q <= '0; rd_vld_q <= 1'b0; found_q <= 1'b0;
		end
		if (cmd.srch_step) begin
			if (rcnt_q != RR_ENTRIES[RR_IDX_BITS:0]) rcnt_q <= rcnt_q + 1'b1;
			rd_vld_q <= 1'b1;
			if (rd_vld_q && rdata == target_q) found_q <= 1'b1;
		end
		if (cmd.scan_start) begin
			scan_q <= '0; scan_vld_s1 <= 1'b0; best_sc_q <= '0; best_off_q <= '0;
		end
		if (cmd.scan_step) begin
			if (scan_vld_s1 && scan_win) begin
				best_sc_q <= sc_rdata;
				best_off_q <= cand_at(scan_s1);
			end
			scan_s1 <= scan_q;
			scan_vld_s1 <= 1'b1;
			if (scan_q != SCAN_LAST[PTR_BITS-1:0]) scan_q <= scan_q + 1'b1;
		end
		if (cmd.out_load) begin
			mark_prefetched <= op_q;
			issue <= iss_q;
			prefetch_addr <= iss_q ? paddr_q : '0;
		end
	end
endmodule
`default_nettype wire

/* design/best_offset_prefetcher.sv */
// Each access does one recent-table read per cycle over all 256 entries, then
// updates a score, and scans the scores at a phase end; a fill skips the search.
// Throughput: one transaction at a time; the next is taken once the previous
// result is loaded into the output register.
// Reset (arst_n, async low): control clears, then a 256-entry clearing pass
// zeroes the recent table and the score table before the first transaction.
`default_nettype none
module best_offset_prefetcher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [5:0]                    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic [bop_pkg::ADDR_BITS-1:0] addr,
	input  wire logic                          miss,
	input  wire logic                          prefetched_hit,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               issue,
	output logic [bop_pkg::ADDR_BITS-1:0]      prefetch_addr,
	output logic                               mark_prefetched
);
	import bop_pkg::*;
	cmd_t cmd;
	sts_t sts;

	// sequence: take, search table, update scores (access) or table (fill), optional best scan, emit
	bop_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	bop_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .addr(addr), .miss(miss), .prefetched_hit(prefetched_hit),
		.out_valid(out_valid), .out_stall(out_stall), .issue(issue),
		.prefetch_addr(prefetch_addr), .mark_prefetched(mark_prefetched)
	);
endmodule
`default_nettype wire

/* design/bop_checker.sv */
`default_nettype none
module bop_sva (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic issue,
	input wire logic mark_prefetched
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(issue && mark_prefetched)) else $error("issue with mark");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("second transaction taken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(issue) && $stable(mark_prefetched)))
		else $error("stalled result changed");
endmodule
bind best_offset_prefetcher bop_sva u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .issue(issue),
	.mark_prefetched(mark_prefetched)
);
`default_nettype wire
